@@ hw/rtl/mhes_pkg.sv @@
// mhes_pkg: shared types and constants for the heap extract/sort block
// no dependencies
package mhes_pkg;
    localparam int CAPACITY_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_SORT    = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    // sift request from sequencer to sift unit
    typedef struct packed {
        logic start;
    } t_sift_ctl;
endpackage

@@ hw/rtl/mhes_if.sv @@
// mhes_if: valid/ready request channels for the heap block
// depends on mhes_pkg
interface mhes_in_if;
    logic                     valid;
    logic                     ready;
    logic [mhes_pkg::CMD_W-1:0] cmd;
    logic signed [mhes_pkg::KEY_W-1:0] key;
    modport source (output valid, cmd, key, input ready);
    modport sink   (input valid, cmd, key, output ready);
endinterface

interface mhes_out_if;
    logic                        valid;
    logic                        ready;
    logic signed [mhes_pkg::KEY_W-1:0] value;
    logic [mhes_pkg::STATUS_W-1:0] status;
    logic                        last;
    modport source (output valid, value, status, last, input ready);
    modport sink   (input valid, value, status, last, output ready);
endinterface

@@ hw/rtl/mhes_sift.sv @@
// mhes_sift: shared sift-down unit owning the key store memory
// depends on mhes_pkg
module mhes_sift #(
    parameter int CAPACITY = mhes_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [AW-1:0]               i_node,
    input  logic [CW-1:0]               i_size,
    input  logic                        i_wr,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [mhes_pkg::KEY_W-1:0]  i_wr_data,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [mhes_pkg::KEY_W-1:0]  o_rd_data,
    output logic                        o_busy
);
    import mhes_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RDN  = 7'b0000010,
        S_RDL  = 7'b0000100,
        S_RDR  = 7'b0001000,
        S_CMP  = 7'b0010000,
        S_WR1  = 7'b0100000,
        S_WR2  = 7'b1000000
    } t_state;

    logic [KEY_W-1:0] r_mem [CAPACITY];
    logic [KEY_W-1:0] r_q;
    t_state           r_state, n_state;
    logic [AW-1:0]    r_node, n_node;
    logic [AW-1:0]    r_top, n_top;
    logic [KEY_W-1:0] r_nval, n_nval;
    logic [KEY_W-1:0] r_tval, n_tval;
    logic [CW-1:0]    r_size;
    logic [CW:0]      w_lc, w_rc;
    logic [AW-1:0]    w_addr;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [KEY_W-1:0] w_wdata;

    assign w_lc = (CW+1)'({r_node, 1'b1});
    assign w_rc = {r_node, 1'b0} + (CW+1)'(2);
    assign o_busy = (r_state != S_IDLE);
    assign o_rd_data = r_q;

    function automatic logic gt(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        gt = $signed(a) > $signed(b);
    endfunction

    always_comb begin
        n_state = r_state;
        n_node  = r_node;
        n_top   = r_top;
        n_nval  = r_nval;
        n_tval  = r_tval;
        w_addr  = i_rd_addr;
        w_we    = 1'b0;
        w_waddr = i_wr_addr;
        w_wdata = i_wr_data;
        case (r_state)
            S_IDLE: begin
                w_we = i_wr;
                if (i_start) begin
                    n_node  = i_node;
                    n_state = S_RDN;
                end
            end
            S_RDN: begin
                w_addr = r_node;
                n_top  = r_node;
                if (w_lc < (CW+1)'(r_size)) begin
                    n_state = S_RDL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RDL: begin
                n_nval = r_q;
                n_tval = r_q;
                w_addr = w_lc[AW-1:0];
                n_state = S_RDR;
            end
            S_RDR: begin
                if (gt(r_q, r_tval)) begin
                    n_tval = r_q;
                    n_top  = w_lc[AW-1:0];
                end
                w_addr = w_rc[AW-1:0];
                n_state = (w_rc < (CW+1)'(r_size)) ? S_CMP : S_WR1;
            end
            S_CMP: begin
                if (gt(r_q, r_tval)) begin
                    n_tval = r_q;
                    n_top  = w_rc[AW-1:0];
                end
                n_state = S_WR1;
            end
            S_WR1: begin
                if (r_top == r_node) begin
                    n_state = S_IDLE;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_node;
                    w_wdata = r_tval;
                    n_state = S_WR2;
                end
            end
            S_WR2: begin
                w_we    = 1'b1;
                w_waddr = r_top;
                w_wdata = r_nval;
                n_node  = r_top;
                n_state = S_RDN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_q <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_node <= n_node;
        r_top  <= n_top;
        r_nval <= n_nval;
        r_tval <= n_tval;
        if (r_state == S_IDLE && i_start) begin
            r_size <= i_size;
        end
    end
endmodule

@@ hw/rtl/max_heap_extract_sort.sv @@
// max_heap_extract_sort: top level, command sequencer around the sift unit
// depends on mhes_pkg, mhes_if, mhes_sift
// A push writes its key into the key store. An extract of a built heap moves
// the last key to the root and sifts it down level by level; the shared sift
// unit reads each node and its children one word at a time. The first extract
// or sort after pushes first rebuilds the heap, N/2 sifts. A sort delivers
// N results after N-1 sifts, each read in S_ORD once the output is free.
// The block takes no new request until all results of the last one are taken.
module max_heap_extract_sort #(
    parameter int CAPACITY = mhes_pkg::CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mhes_in_if.sink    i_req,
    mhes_out_if.source o_res
);
    import mhes_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_BUILD = 12'b000000000010,
        S_BWAIT = 12'b000000000100,
        S_XRD0  = 12'b000000001000,
        S_XRDL  = 12'b000000010000,
        S_XW0   = 12'b000000100000,
        S_XWL   = 12'b000001000000,
        S_SIFT  = 12'b000010000000,
        S_SWAIT = 12'b000100000000,
        S_ORD   = 12'b001000000000,
        S_OUT   = 12'b010000000000,
        S_PUSH  = 12'b100000000000
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_built, n_built;
    logic [1:0]       r_cmd, n_cmd;
    logic [KEY_W-1:0] r_key, n_key;
    logic [AW:0]      r_k, n_k;
    logic [CW-1:0]    r_n, n_n;
    logic [KEY_W-1:0] r_root, n_root;
    logic [KEY_W-1:0] r_val, n_val;
    logic [1:0]       r_st, n_st;
    logic             r_last, n_last;
    logic             r_ov, n_ov;

    logic             w_start, w_wr, w_busy;
    logic [AW-1:0]    w_node, w_waddr, w_raddr;
    logic [CW-1:0]    w_size;
    logic [KEY_W-1:0] w_wdata, w_rdata;

    mhes_sift #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_sift (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_node(w_node),
        .i_size(w_size), .i_wr(w_wr), .i_wr_addr(w_waddr), .i_wr_data(w_wdata),
        .i_rd_addr(w_raddr), .o_rd_data(w_rdata), .o_busy(w_busy)
    );

    assign i_req.ready  = (r_state == S_IDLE) && !r_ov;
    assign o_res.valid  = r_ov;
    assign o_res.value  = r_val;
    assign o_res.status = r_st;
    assign o_res.last   = r_last;

    always_comb begin
        n_state = r_state; n_count = r_count; n_built = r_built;
        n_cmd = r_cmd; n_key = r_key; n_k = r_k; n_n = r_n;
        n_root = r_root; n_val = r_val; n_st = r_st; n_last = r_last;
        n_ov = r_ov && !o_res.ready;
        w_start = 1'b0; w_node = '0; w_size = r_count;
        w_wr = 1'b0; w_waddr = '0; w_wdata = r_key; w_raddr = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid && !r_ov) begin
                    n_cmd = i_req.cmd;
                    n_key = i_req.key;
                    n_val = '0; n_last = 1'b1;
                    case (t_cmd'(i_req.cmd))
                        CMD_PUSH: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_st = ST_FULL; n_ov = 1'b1;
                            end else begin
                                n_state = S_PUSH;
                            end
                        end
                        CMD_EXTRACT, CMD_SORT: begin
                            if (r_count == '0) begin
                                n_st = ST_EMPTY; n_ov = 1'b1;
                            end else begin
                                n_n = r_count;
                                if (r_built) begin
                                    n_k = (AW+1)'(r_count - 1'b1);
                                    n_state = S_XRD0;
                                end else begin
                                    n_k = (AW+1)'(r_count >> 1);
                                    n_state = S_BUILD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PUSH: begin
                w_wr = 1'b1; w_waddr = r_count[AW-1:0]; w_wdata = r_key;
                n_count = r_count + 1'b1; n_built = 1'b0;
                n_val = '0; n_st = ST_OK; n_last = 1'b1; n_ov = 1'b1;
                n_state = S_IDLE;
            end
            S_BUILD: begin
                if (r_k == '0) begin
                    n_built = 1'b1;
                    n_k = (AW+1)'(r_count - 1'b1);
                    n_state = S_XRD0;
                end else begin
                    w_start = 1'b1; w_node = AW'(r_k - 1'b1); w_size = r_count;
                    n_k = r_k - 1'b1;
                    n_state = S_BWAIT;
                end
            end
            S_BWAIT: if (!w_busy) n_state = S_BUILD;
            S_XRD0: begin
                // k is the last index of the shrinking heap
                if (r_cmd == CMD_EXTRACT) n_k = (AW+1)'(r_count - 1'b1);
                if (r_cmd == CMD_SORT && r_k == '0) begin
                    n_k = '0; n_state = S_ORD;
                end else begin
                    w_raddr = '0;
                    n_state = S_XRDL;
                end
            end
            S_XRDL: begin
                n_root = w_rdata;
                w_raddr = r_k[AW-1:0];
                n_state = S_XW0;
            end
            S_XW0: begin
                w_wr = 1'b1; w_waddr = '0; w_wdata = w_rdata;
                n_state = S_XWL;
            end
            S_XWL: begin
                w_wr = 1'b1; w_waddr = r_k[AW-1:0]; w_wdata = r_root;
                n_state = S_SIFT;
            end
            S_SIFT: begin
                w_start = 1'b1; w_node = '0; w_size = CW'(r_k);
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                if (!w_busy) begin
                    if (r_cmd == CMD_EXTRACT) begin
                        n_count = r_count - 1'b1;
                        n_val = r_root; n_st = ST_OK; n_last = 1'b1; n_ov = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k - 1'b1;
                        n_state = S_XRD0;
                    end
                end
            end
            S_ORD: begin
                if (!r_ov || o_res.ready) begin
                    w_raddr = r_k[AW-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_val = w_rdata; n_st = ST_OK; n_ov = 1'b1;
                n_last = (CW'(r_k) + 1'b1 == r_n);
                n_k = r_k + 1'b1;
                if (CW'(r_k) + 1'b1 == r_n) begin
                    n_count = '0; n_built = 1'b0; n_state = S_IDLE;
                end else begin
                    n_state = S_ORD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_built <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_built <= n_built;
            r_ov    <= n_ov;
        end
        r_cmd <= n_cmd; r_key <= n_key; r_k <= n_k; r_n <= n_n;
        r_root <= n_root; r_val <= n_val; r_st <= n_st; r_last <= n_last;
    end
endmodule

@@ tb/tb_top.sv @@
// tb_top: random and directed regression of the heap extract/sort block
// depends on mhes_pkg, mhes_if and the max_heap_extract_sort rtl
module tb_top;
    import mhes_pkg::*;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] key;
    } t_request;

    typedef struct packed {
        logic [31:0] value;
        t_status     status;
        logic        last;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    mhes_in_if  req_if ();
    mhes_out_if res_if ();

    max_heap_extract_sort u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    t_request    pending_q[$];
    t_result     result_q[$];
    logic [31:0] heap_keys[CAPACITY_DEF];
    int          heap_len;
    bit          heap_ok;
    bit          req_taken;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          fail_cnt;
    int          cycle_cnt;
    int          sent_cnt;
    int          got_cnt;
    int          sort_cnt;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit key_greater(logic [31:0] a, logic [31:0] b);
        return $signed(a) > $signed(b);
    endfunction

    function automatic void sift(int size, int node);
        int          top;
        logic [31:0] tmp;
        forever begin
            top = node;
            if (2 * node + 1 < size && key_greater(heap_keys[2 * node + 1], heap_keys[top]))
                top = 2 * node + 1;
            if (2 * node + 2 < size && key_greater(heap_keys[2 * node + 2], heap_keys[top]))
                top = 2 * node + 2;
            if (top == node)
                return;
            tmp = heap_keys[node];
            heap_keys[node] = heap_keys[top];
            heap_keys[top] = tmp;
            node = top;
        end
    endfunction

    function automatic void heapify_keys();
        if (!heap_ok) begin
            for (int k = heap_len / 2; k > 0; k--)
                sift(heap_len, k - 1);
            heap_ok = 1'b1;
        end
    endfunction

    function automatic void predict_heap(t_request rq);
        logic [31:0] tmp;
        case (rq.cmd)
            CMD_PUSH: begin
                if (heap_len >= CAPACITY_DEF) begin
                    result_q.push_back('{32'd0, ST_FULL, 1'b1});
                end else begin
                    heap_keys[heap_len] = rq.key;
                    heap_len++;
                    heap_ok = 1'b0;
                    result_q.push_back('{32'd0, ST_OK, 1'b1});
                end
            end
            CMD_EXTRACT: begin
                if (heap_len == 0) begin
                    result_q.push_back('{32'd0, ST_EMPTY, 1'b1});
                end else begin
                    heapify_keys();
                    tmp = heap_keys[0];
                    heap_keys[0] = heap_keys[heap_len - 1];
                    heap_len--;
                    sift(heap_len, 0);
                    result_q.push_back('{tmp, ST_OK, 1'b1});
                end
            end
            CMD_SORT: begin
                if (heap_len == 0) begin
                    result_q.push_back('{32'd0, ST_EMPTY, 1'b1});
                end else begin
                    heapify_keys();
                    for (int k = heap_len - 1; k > 0; k--) begin
                        tmp = heap_keys[0];
                        heap_keys[0] = heap_keys[k];
                        heap_keys[k] = tmp;
                        sift(k, 0);
                    end
                    for (int k = 0; k < heap_len; k++)
                        result_q.push_back('{heap_keys[k], ST_OK, k == heap_len - 1});
                    heap_len = 0;
                    heap_ok = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 7) - 4;
            3: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid && !req_taken) begin
        end else if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_if.valid <= 1'b1;
            req_if.cmd   <= pending_q[0].cmd;
            req_if.key   <= pending_q[0].key;
            void'(pending_q.pop_front());
        end else begin
            req_if.valid <= 1'b0;
        end
        res_if.ready <= i_rst_n && $urandom_range(0, 99) >= recv_stall_pct;
    end

    // monitor
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            predict_heap('{t_cmd'(req_if.cmd), req_if.key});
            sent_cnt <= sent_cnt + 1;
            if (req_if.cmd == CMD_SORT)
                sort_cnt <= sort_cnt + 1;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_cnt <= got_cnt + 1;
            if (result_q.size() == 0) begin
                $display("%0t unexpected result value=%h status=%0d last=%0b", $time,
                         res_if.value, res_if.status, res_if.last);
                fail_cnt <= fail_cnt + 1;
            end else begin
                if (result_q[0] !== t_result'({res_if.value, res_if.status, res_if.last})) begin
                    $display("%0t mismatch exp value=%h status=%0d last=%0b", $time,
                             result_q[0].value, result_q[0].status, result_q[0].last);
                    $display("%0t          act value=%h status=%0d last=%0b", $time,
                             res_if.value, res_if.status, res_if.last);
                    fail_cnt <= fail_cnt + 1;
                end
                void'(result_q.pop_front());
            end
        end
        if (cycle_cnt > 5000000) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     result_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic queue_req(t_cmd c, logic [31:0] k);
        pending_q.push_back('{c, k});
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n);
        int fill;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            // random mix weighted toward pushes, with extracts, some sorts and unused commands
            fill = $urandom_range(0, 9);
            if (fill < 5)
                queue_req(CMD_PUSH, rand_key());
            else if (fill < 8)
                queue_req(CMD_EXTRACT, rand_key());
            else if (fill < 9)
                queue_req($urandom_range(0, 3) == 0 ? CMD_SORT : CMD_PUSH, rand_key());
            else
                queue_req($urandom_range(0, 1) ? CMD_NONE : CMD_SORT, rand_key());
        end
        wait (pending_q.size() == 0 && !req_if.valid);
        wait (result_q.size() == 0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.cmd = CMD_PUSH;
        req_if.key = '0;
        res_if.ready = 1'b0;
        heap_len = 0;
        heap_ok = 1'b0;
        fail_cnt = 0;
        cycle_cnt = 0;
        sent_cnt = 0;
        got_cnt = 0;
        sort_cnt = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty cases, extremes, ties, unused command, sort, full store
        queue_req(CMD_EXTRACT, 32'h0);
        queue_req(CMD_SORT, 32'h0);
        queue_req(CMD_NONE, 32'hffff_ffff);
        queue_req(CMD_PUSH, 32'h8000_0000);
        queue_req(CMD_PUSH, 32'h7fff_ffff);
        queue_req(CMD_PUSH, 32'h0);
        queue_req(CMD_PUSH, 32'hffff_ffff);
        queue_req(CMD_PUSH, 32'h5);
        queue_req(CMD_PUSH, 32'h5);
        queue_req(CMD_EXTRACT, 32'h0);
        queue_req(CMD_PUSH, 32'h7fff_ffff);
        queue_req(CMD_EXTRACT, 32'h0);
        queue_req(CMD_SORT, 32'h0);
        queue_req(CMD_EXTRACT, 32'h0);
        for (int i = 0; i < CAPACITY_DEF + 1; i++)
            queue_req(CMD_PUSH, $urandom);
        queue_req(CMD_SORT, 32'h0);
        wait (pending_q.size() == 0 && !req_if.valid);
        wait (result_q.size() == 0);

        run_phase(0, 0, 30);
        run_phase(68, 0, 30);
        run_phase(0, 68, 30);
        run_phase(38, 38, 40);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (200) @(posedge i_clk);

        $display("covered %0d requests and %0d results, %0d sort requests, in %0d cycles",
                 sent_cnt, got_cnt, sort_cnt, cycle_cnt);
        if (fail_cnt == 0 && result_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
